FILE: rtl/core/ftn_pkg.sv
// Package with the shared types and constants of the frame timestamp normalizer.
package ftn_pkg;

  localparam int unsigned StampW  = 48;
  localparam int unsigned LengthW = 32;
  localparam int unsigned TimeW   = 47;
  localparam int unsigned DurW    = 31;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 48;

  localparam logic [DurW-1:0]  DefaultLength = DurW'(33333);
  localparam logic [TimeW-1:0] TimeMax       = {TimeW{1'b1}};

  localparam logic [CfgIdxW-1:0] CfgOriginPresent  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTimelineOrigin = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgNominalPresent = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgNominalDur     = 2'd3;

  typedef struct packed {
    logic                      origin_present;
    logic signed [StampW-1:0]  timeline_origin;
    logic                      nominal_present;
    logic signed [LengthW-1:0] nominal_duration;
  } cfg_t;

  typedef struct packed {
    logic                      stamp_present;
    logic signed [StampW-1:0]  stamp;
    logic                      length_present;
    logic signed [LengthW-1:0] length;
  } frame_t;

  typedef struct packed {
    logic [TimeW-1:0] presentation_time;
    logic [DurW-1:0]  frame_duration;
  } result_t;

endpackage

FILE: rtl/core/ftn_cfg.sv
// Configuration register file of the frame timestamp normalizer.
module ftn_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [ftn_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [ftn_pkg::CfgDatW-1:0]        cfg_data,
  output ftn_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ftn_pkg::CfgOriginPresent:  cfg.origin_present   <= cfg_data[0];
        ftn_pkg::CfgTimelineOrigin: cfg.timeline_origin  <= cfg_data[ftn_pkg::StampW-1:0];
        ftn_pkg::CfgNominalPresent: cfg.nominal_present  <= cfg_data[0];
        ftn_pkg::CfgNominalDur:     cfg.nominal_duration <= cfg_data[ftn_pkg::LengthW-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/ftn_calc.sv
// Timeline state and per-frame presentation time and duration logic.
module ftn_calc (
  input  logic              clk,
  input  logic              rst,
  input  ftn_pkg::cfg_t     cfg,
  input  ftn_pkg::frame_t   frame,
  input  logic              fire,
  output ftn_pkg::result_t  result
);

  localparam int unsigned SumW = ftn_pkg::StampW + 1;

  logic                              first_seen;
  logic signed [ftn_pkg::StampW-1:0] first_stamp;
  logic                              last_seen;
  logic [ftn_pkg::TimeW-1:0]         last_time;
  logic [ftn_pkg::DurW-1:0]          last_length;

  logic signed [ftn_pkg::StampW-1:0]  base;
  logic signed [SumW-1:0]             raw;
  logic [ftn_pkg::StampW-1:0]         clamped;
  logic [ftn_pkg::StampW-1:0]         mono;
  logic [ftn_pkg::TimeW-1:0]          t;
  logic signed [ftn_pkg::LengthW-1:0] d_sel;
  logic [ftn_pkg::DurW-1:0]           d;

  always_comb begin
    if (cfg.origin_present) begin
      base = cfg.timeline_origin;
    end else if (first_seen) begin
      base = first_stamp;
    end else begin
      base = frame.stamp;
    end

    if (frame.stamp_present) begin
      raw = SumW'(frame.stamp) - SumW'(base);
    end else if (last_seen) begin
      raw = $signed({2'b00, last_time}) + $signed({{(SumW-ftn_pkg::DurW){1'b0}}, last_length});
    end else begin
      raw = '0;
    end

    clamped = raw[SumW-1] ? '0 : raw[ftn_pkg::StampW-1:0];
    if (last_seen && (clamped < {1'b0, last_time})) begin
      mono = {1'b0, last_time};
    end else begin
      mono = clamped;
    end
    t = mono[ftn_pkg::StampW-1] ? ftn_pkg::TimeMax : mono[ftn_pkg::TimeW-1:0];

    priority if (frame.length_present) begin
      d_sel = frame.length;
    end else if (cfg.nominal_present) begin
      d_sel = cfg.nominal_duration;
    end else begin
      d_sel = $signed({1'b0, last_length});
    end
    d = (d_sel <= 0) ? ftn_pkg::DefaultLength : d_sel[ftn_pkg::DurW-1:0];
  end

  assign result.presentation_time = t;
  assign result.frame_duration    = d;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_seen  <= 1'b0;
      first_stamp <= '0;
      last_seen   <= 1'b0;
      last_time   <= '0;
      last_length <= '0;
    end else if (fire) begin
      if (frame.stamp_present && !cfg.origin_present && !first_seen) begin
        first_seen  <= 1'b1;
        first_stamp <= frame.stamp;
      end
      last_seen   <= 1'b1;
      last_time   <= t;
      last_length <= d;
    end
  end

endmodule

FILE: rtl/core/frame_timestamp_normalizer.sv
// Top level of the frame timestamp normalizer: request and result registers around the logic.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+------------------------------------------------
//  in      | in_valid/in_stall  | stamp_present, stamp, length_present, length
//  out     | out_valid/out_stall| presentation_time, frame_duration
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A request passes through the request register and then the result register, and one
// request is taken per cycle while the result is not stalled.
// The timeline state updates in the cycle a request leaves the request register.
// Reset is synchronous and clears all control state and the configuration registers.
// A stalled result holds the pipe; in_stall rises only when the request register is full
// and cannot move.
module frame_timestamp_normalizer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                stamp_present,
  input  logic signed [ftn_pkg::StampW-1:0]   stamp,
  input  logic                                length_present,
  input  logic signed [ftn_pkg::LengthW-1:0]  length,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ftn_pkg::TimeW-1:0]           presentation_time,
  output logic [ftn_pkg::DurW-1:0]            frame_duration,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ftn_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [ftn_pkg::CfgDatW-1:0]         cfg_data
);

  ftn_pkg::cfg_t    cfg;
  ftn_pkg::frame_t  req;
  ftn_pkg::result_t res;
  logic             req_valid;
  logic             fire;
  logic             in_take;

  assign cfg_ready = 1'b1;
  assign fire      = req_valid && (!out_valid || !out_stall);
  assign in_stall  = req_valid && !fire;
  assign in_take   = in_valid && !in_stall;

  ftn_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ftn_calc u_calc (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .frame  (req),
    .fire   (fire),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        req_valid <= 1'b1;
      end else if (fire) begin
        req_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req.stamp_present  <= stamp_present;
      req.stamp          <= stamp;
      req.length_present <= length_present;
      req.length         <= length;
    end
    if (fire) begin
      presentation_time <= res.presentation_time;
      frame_duration    <= res.frame_duration;
    end
  end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the frame timestamp normalizer with directed and random frames.
module tb_top;

  localparam int     CycleLimit = 300000;
  localparam longint StampMax   = 64'sd140737488355327;
  localparam longint StampMin   = -64'sd140737488355328;
  localparam longint LengthMax  = 64'sd2147483647;
  localparam longint LengthMin  = -64'sd2147483648;
  localparam longint TimeTop    = 64'sd140737488355327;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic                               stamp_present = 1'b0;
  logic signed [ftn_pkg::StampW-1:0]  stamp = '0;
  logic                               length_present = 1'b0;
  logic signed [ftn_pkg::LengthW-1:0] length = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [ftn_pkg::TimeW-1:0]          presentation_time;
  logic [ftn_pkg::DurW-1:0]           frame_duration;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [ftn_pkg::CfgIdxW-1:0]        cfg_index = '0;
  logic [ftn_pkg::CfgDatW-1:0]        cfg_data = '0;

  logic             origin_on = 1'b0;
  longint           origin_val = 0;
  logic             nominal_on = 1'b0;
  longint           nominal_val = 0;
  logic             first_on = 1'b0;
  longint           first_val = 0;
  logic             last_on = 1'b0;
  longint           last_t = 0;
  longint           last_d = 0;
  ftn_pkg::result_t scheduled_q[$];
  ftn_pkg::result_t due;
  int               mismatches = 0;
  int               burst_left = 0;
  int               hold_left = 0;
  int               stall_pct = 0;
  int               stall_span = 0;
  int               cycle_count = 0;

  frame_timestamp_normalizer u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic ftn_pkg::result_t schedule_frame(input ftn_pkg::frame_t f);
    longint           t;
    longint           d;
    ftn_pkg::result_t r;
    t = 0;
    if (f.stamp_present) begin
      if (origin_on) begin
        t = longint'($signed(f.stamp)) - origin_val;
      end else begin
        if (!first_on) begin
          first_on = 1'b1;
          first_val = longint'($signed(f.stamp));
        end
        t = longint'($signed(f.stamp)) - first_val;
      end
    end else if (last_on) begin
      t = last_t + last_d;
    end
    if (t < 0) begin
      t = 0;
    end
    if (last_on && t < last_t) begin
      t = last_t;
    end
    if (t > TimeTop) begin
      t = TimeTop;
    end
    if (f.length_present) begin
      d = longint'($signed(f.length));
    end else if (nominal_on) begin
      d = nominal_val;
    end else begin
      d = last_d;
    end
    if (d <= 0) begin
      d = longint'(ftn_pkg::DefaultLength);
    end
    last_on = 1'b1;
    last_t = t;
    last_d = d;
    r.presentation_time = t[ftn_pkg::TimeW-1:0];
    r.frame_duration = d[ftn_pkg::DurW-1:0];
    return r;
  endfunction

  function automatic longint rand_stamp_bits();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return longint'($signed(raw[ftn_pkg::StampW-1:0]));
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  task automatic write_reg(input logic [ftn_pkg::CfgIdxW-1:0] idx, input longint val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[ftn_pkg::CfgDatW-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ftn_pkg::CfgOriginPresent: begin
        origin_on = val[0];
      end
      ftn_pkg::CfgTimelineOrigin: begin
        origin_val = longint'($signed(val[ftn_pkg::StampW-1:0]));
      end
      ftn_pkg::CfgNominalPresent: begin
        nominal_on = val[0];
      end
      ftn_pkg::CfgNominalDur: begin
        nominal_val = longint'($signed(val[ftn_pkg::LengthW-1:0]));
      end
      default: begin
      end
    endcase
  endtask

  task automatic apply_timeline(input logic o_on, input longint o_val,
                                input logic n_on, input longint n_val);
    write_reg(ftn_pkg::CfgOriginPresent, longint'(o_on));
    write_reg(ftn_pkg::CfgTimelineOrigin, o_val);
    write_reg(ftn_pkg::CfgNominalPresent, longint'(n_on));
    write_reg(ftn_pkg::CfgNominalDur, n_val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame(input logic sp, input longint st, input logic lp, input longint ln);
    ftn_pkg::frame_t f;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
    end
    burst_left--;
    f.stamp_present = sp;
    f.stamp = st[ftn_pkg::StampW-1:0];
    f.length_present = lp;
    f.length = ln[ftn_pkg::LengthW-1:0];
    in_valid <= 1'b1;
    stamp_present <= f.stamp_present;
    stamp <= f.stamp;
    length_present <= f.length_present;
    length <= f.length;
    // Hold the request until the block takes it.
    do @(posedge clk); while (in_stall);
    scheduled_q.insert(scheduled_q.size(), schedule_frame(f));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (scheduled_q.size() != 0);
  endtask

  task automatic test_reset_state();
    send_frame(1'b0, 0, 1'b0, 0);
    send_frame(1'b0, 12345, 1'b1, -7);
    drain_results();
  endtask

  task automatic test_origin_before_first();
    apply_timeline(1'b1, 500000, 1'b0, 0);
    send_frame(1'b1, 2000000, 1'b1, 40000);
    send_frame(1'b1, 100000, 1'b0, 0);
    drain_results();
    apply_timeline(1'b0, 500000, 1'b0, 0);
    send_frame(1'b1, 3000000, 1'b1, 0);
    send_frame(1'b0, 0, 1'b0, 0);
    send_frame(1'b1, 5000000, 1'b1, LengthMax);
    send_frame(1'b0, 0, 1'b1, LengthMin);
    drain_results();
  endtask

  task automatic test_stamp_extremes();
    apply_timeline(1'b1, StampMax, 1'b0, 0);
    send_frame(1'b1, StampMax, 1'b1, 33333);
    send_frame(1'b1, StampMin, 1'b0, LengthMin);
    drain_results();
    apply_timeline(1'b1, StampMin, 1'b0, 0);
    send_frame(1'b1, StampMin, 1'b1, 50000);
    send_frame(1'b1, StampMin + last_t + 1000, 1'b1, 50000);
    drain_results();
  endtask

  task automatic test_nominal_fallback();
    apply_timeline(1'b0, 0, 1'b1, LengthMax);
    send_frame(1'b1, first_val + last_t + 10000, 1'b0, 0);
    drain_results();
    apply_timeline(1'b0, 0, 1'b1, 0);
    send_frame(1'b0, 0, 1'b0, 0);
    drain_results();
    apply_timeline(1'b0, 0, 1'b1, LengthMin);
    send_frame(1'b0, 0, 1'b0, 0);
    drain_results();
    apply_timeline(1'b0, 0, 1'b1, 1);
    send_frame(1'b0, 0, 1'b0, 0);
    drain_results();
    apply_timeline(1'b0, 0, 1'b0, 5000);
    send_frame(1'b0, 0, 1'b0, 0);
    drain_results();
  endtask

  task automatic test_random_stream(input int frames);
    int     i;
    logic   o_on;
    logic   n_on;
    logic   sp;
    logic   lp;
    longint o_val;
    longint n_val;
    longint base;
    longint st;
    longint ln;
    o_on = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 4))
      0: o_val = 0;
      1: o_val = StampMin;
      2: o_val = StampMax;
      3: o_val = longint'($urandom_range(0, 2000000)) - 1000000;
      default: o_val = rand_stamp_bits();
    endcase
    n_on = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 6))
      0: n_val = 0;
      1: n_val = -1;
      2: n_val = LengthMin;
      3: n_val = LengthMax;
      4: n_val = 33333;
      5: n_val = longint'($urandom_range(1000, 100000));
      default: n_val = longint'($signed($urandom()));
    endcase
    apply_timeline(o_on, o_val, n_on, n_val);
    for (i = 0; i < frames; i++) begin
      base = origin_on ? origin_val : first_val;
      sp = ($urandom_range(0, 99) < 85);
      if (!sp) begin
        st = rand_stamp_bits();
      end else begin
        case ($urandom_range(0, 9))
          0: st = base + last_t - longint'($urandom_range(0, 3000000));
          1: st = base - longint'($urandom_range(1, 1000000));
          default: st = base + last_t + longint'($urandom_range(0, 80000));
        endcase
      end
      lp = ($urandom_range(0, 99) < 70);
      case ($urandom_range(0, 9))
        0: ln = -longint'($urandom_range(0, 5));
        1: ln = longint'($signed($urandom()));
        default: ln = longint'($urandom_range(1000, 100000));
      endcase
      send_frame(sp, st, lp, ln);
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    int     i;
    longint base;
    base = origin_on ? origin_val : first_val;
    hold_left = 300;
    burst_left = 1000000;
    for (i = 0; i < 80; i++) begin
      send_frame(1'b1, base + last_t + 33333, 1'($urandom_range(0, 1)), 40000);
    end
    drain_results();
  endtask

  task automatic test_noise(input int frames);
    int i;
    apply_timeline(1'($urandom_range(0, 1)), rand_stamp_bits(),
                   1'($urandom_range(0, 1)), longint'($signed($urandom())));
    for (i = 0; i < frames; i++) begin
      send_frame(1'($urandom_range(0, 1)), rand_stamp_bits(),
                 1'($urandom_range(0, 1)), longint'($signed($urandom())));
    end
    drain_results();
  endtask

  task automatic test_saturation();
    apply_timeline(1'b1, StampMin, 1'b0, 0);
    send_frame(1'b1, StampMax, 1'b1, 33333);
    send_frame(1'b0, 0, 1'b0, 0);
    send_frame(1'b1, 0, 1'b1, 1);
    drain_results();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      if (stall_span == 0) begin
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 20;
          3: stall_pct = 50;
          default: stall_pct = 85;
        endcase
        stall_span = $urandom_range(16, 128);
      end
      stall_span--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (scheduled_q.size() == 0) begin
        report_mismatch("result with no frame outstanding");
      end else begin
        due = scheduled_q[0];
        scheduled_q.delete(0);
        if (presentation_time !== due.presentation_time) begin
          report_mismatch($sformatf("presentation_time %0d, want %0d",
                                    presentation_time, due.presentation_time));
        end
        if (frame_duration !== due.frame_duration) begin
          report_mismatch($sformatf("frame_duration %0d, want %0d",
                                    frame_duration, due.frame_duration));
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int p;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_origin_before_first();
    test_stamp_extremes();
    test_nominal_fallback();
    for (p = 0; p < 10; p++) begin
      test_random_stream(140);
      if (p == 4) begin
        test_backpressure();
      end
    end
    test_noise(150);
    test_saturation();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
